// ===== rtl/fbf_pkg.sv =====
// Shared types, widths, register codes and the quarter-wave cosine table
// for the Fourier basis feature block. No dependencies.
package fbf_pkg;

  localparam int MAX_VARS        = 3;
  localparam int MAX_ORDER       = 3;
  localparam int SCALE_FRAC_BITS = 16;

  localparam int VAL_W      = 16;                   // Q8.8 inputs and bounds
  localparam int ORDER_W    = 2;
  localparam int VCNT_W     = 2;
  localparam int SCALED_W   = SCALE_FRAC_BITS + 1;  // normalized value and phase
  localparam int LERP_BITS  = SCALE_FRAC_BITS - 6;
  localparam int COS_W      = 15;                   // cosine magnitude
  localparam int FEAT_W     = 16;
  localparam int TERM_W     = 6;
  localparam int DIV_STEPS  = SCALE_FRAC_BITS + 1;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [ORDER_W-1:0]     ORDER_RST = ORDER_W'(1);
  localparam logic [VCNT_W-1:0]      VCNT_RST  = VCNT_W'(3);
  localparam logic signed [VAL_W-1:0] LOW_RST  = '0;
  localparam logic signed [VAL_W-1:0] HIGH_RST = VAL_W'(256);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASIS_ORDER = 4'd0,
    REG_VAR_COUNT   = 4'd1,
    REG_LOW_0       = 4'd2,
    REG_HIGH_0      = 4'd3,
    REG_LOW_1       = 4'd4,
    REG_HIGH_1      = 4'd5,
    REG_LOW_2       = 4'd6,
    REG_HIGH_2      = 4'd7
  } cfg_reg_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] var_value_0;
    logic signed [VAL_W-1:0] var_value_1;
    logic signed [VAL_W-1:0] var_value_2;
  } in_word_t;

  typedef struct packed {
    logic [TERM_W-1:0]        term_index;
    logic signed [FEAT_W-1:0] feature_value;
    logic                     range_error;
    logic                     last_term;
  } out_word_t;

  // round(16384*cos(k*pi/64)), k = 0..32
  function automatic logic [COS_W-1:0] cos_tab(input logic [5:0] k);
    logic [COS_W-1:0] v;
    case (k)
      6'd0:  v = 15'd16384;
      6'd1:  v = 15'd16364;
      6'd2:  v = 15'd16305;
      6'd3:  v = 15'd16207;
      6'd4:  v = 15'd16069;
      6'd5:  v = 15'd15893;
      6'd6:  v = 15'd15679;
      6'd7:  v = 15'd15426;
      6'd8:  v = 15'd15137;
      6'd9:  v = 15'd14811;
      6'd10: v = 15'd14449;
      6'd11: v = 15'd14053;
      6'd12: v = 15'd13623;
      6'd13: v = 15'd13160;
      6'd14: v = 15'd12665;
      6'd15: v = 15'd12140;
      6'd16: v = 15'd11585;
      6'd17: v = 15'd11003;
      6'd18: v = 15'd10394;
      6'd19: v = 15'd9760;
      6'd20: v = 15'd9102;
      6'd21: v = 15'd8423;
      6'd22: v = 15'd7723;
      6'd23: v = 15'd7005;
      6'd24: v = 15'd6270;
      6'd25: v = 15'd5520;
      6'd26: v = 15'd4756;
      6'd27: v = 15'd3981;
      6'd28: v = 15'd3196;
      6'd29: v = 15'd2404;
      6'd30: v = 15'd1606;
      6'd31: v = 15'd804;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/fbf_div.sv =====
// Shared restoring divider: floor((dividend << SCALE_FRAC_BITS) / divisor),
// one quotient bit per cycle, for dividend <= divisor. Uses fbf_pkg.
module fbf_div (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic [fbf_pkg::VAL_W-1:0]            dividend,
  input  logic [fbf_pkg::VAL_W-1:0]            divisor,
  output logic                                 done,
  output logic [fbf_pkg::SCALED_W-1:0]         quotient
);

  logic                              busy_r, busy_nxt;
  logic                              done_r, done_nxt;
  logic [fbf_pkg::DIV_CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [fbf_pkg::VAL_W:0]           rem_r, rem_nxt;
  logic [fbf_pkg::VAL_W-1:0]         dvs_r, dvs_nxt;
  logic [fbf_pkg::SCALED_W-1:0]      quo_r, quo_nxt;
  logic [fbf_pkg::VAL_W:0]           rem_sub;
  logic                              ge;

  assign rem_sub = rem_r - {1'b0, dvs_r};
  assign ge      = rem_r >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = fbf_pkg::DIV_CNT_W'(fbf_pkg::DIV_STEPS);
      rem_nxt  = {1'b0, dividend};
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[fbf_pkg::SCALED_W-2:0], ge};
      rem_nxt = ge ? {rem_sub[fbf_pkg::VAL_W-1:0], 1'b0} : {rem_r[fbf_pkg::VAL_W-1:0], 1'b0};
      cnt_nxt = cnt_r - fbf_pkg::DIV_CNT_W'(1);
      if (cnt_r == fbf_pkg::DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== rtl/fbf_cos.sv =====
// Cosine of a phase in half-turns: quadrant fold, quarter-wave table and
// truncated linear interpolation, Q1.14 result. Uses fbf_pkg.
module fbf_cos (
  input  logic [fbf_pkg::SCALED_W-1:0]       phase,
  output logic signed [fbf_pkg::FEAT_W-1:0]  feature
);

  localparam int QW = fbf_pkg::SCALE_FRAC_BITS;

  logic [1:0]                              quad;
  logic [QW-1:0]                           q;
  logic [QW-1:0]                           a;
  logic [5:0]                              idx;
  logic [fbf_pkg::LERP_BITS-1:0]           frac;
  logic [fbf_pkg::COS_W-1:0]               hi, lo, diff, mag;
  logic [fbf_pkg::COS_W+fbf_pkg::LERP_BITS-1:0] prod;

  always_comb begin
    quad = phase[fbf_pkg::SCALED_W-1 -: 2];
    q    = {1'b0, phase[QW-2:0]};
    a    = quad[0] ? ((QW'(1) << (QW - 1)) - q) : q;
    idx  = a[QW-1:fbf_pkg::LERP_BITS];
    frac = a[fbf_pkg::LERP_BITS-1:0];
    hi   = fbf_pkg::cos_tab(idx);
    lo   = fbf_pkg::cos_tab(idx + 6'd1);
    diff = hi - lo;
    prod = (fbf_pkg::COS_W + fbf_pkg::LERP_BITS)'(diff)
         * (fbf_pkg::COS_W + fbf_pkg::LERP_BITS)'(frac);
    mag  = a[QW-1] ? '0 : (hi - prod[fbf_pkg::LERP_BITS +: fbf_pkg::COS_W]);
    feature = (quad[1] ^ quad[0]) ? -fbf_pkg::FEAT_W'(mag) : fbf_pkg::FEAT_W'(mag);
  end

endmodule

// ===== rtl/fourier_basis_features_top.sv =====
// Fourier basis feature expansion: config registers, sequencer, term pipeline.
// Uses fbf_pkg, fbf_div, fbf_cos.
// Each variable in use gets a bound check, then a 17-step divide on the single shared
//   divider. A new input word is accepted only while the sequencer is idle, after the
//   last term of the previous word is pushed. A bound failure on any variable ends
//   the word with one error word instead of its terms.
// Reset: synchronous active-low; registers return to order 1, 3 variables,
//   bounds [0, 1.0]; sequencer idle, output empty.
module fourier_basis_features_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  fbf_pkg::in_word_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output fbf_pkg::out_word_t                 out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [fbf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fbf_pkg::CFG_DATA_W-1:0]     cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_DIV   = 5'b00100,
    S_TERMS = 5'b01000,
    S_ERR   = 5'b10000
  } state_t;

  typedef struct packed {
    logic [fbf_pkg::SCALED_W-1:0] phase;
    logic [fbf_pkg::TERM_W-1:0]   term;
    logic                         last;
    logic                         err;
  } term_stage_t;

  // config registers
  logic [fbf_pkg::ORDER_W-1:0]       order_r;
  logic [fbf_pkg::VCNT_W-1:0]        vcount_r;
  logic signed [fbf_pkg::VAL_W-1:0]  low_r  [fbf_pkg::MAX_VARS];
  logic signed [fbf_pkg::VAL_W-1:0]  high_r [fbf_pkg::MAX_VARS];

  // sequencer
  state_t                            state_r, state_nxt;
  logic [1:0]                        j_r, j_nxt;
  logic [fbf_pkg::ORDER_W-1:0]       digit_r [fbf_pkg::MAX_VARS];
  logic [fbf_pkg::ORDER_W-1:0]       digit_nxt [fbf_pkg::MAX_VARS];
  logic [fbf_pkg::ORDER_W-1:0]       odo_next [fbf_pkg::MAX_VARS];
  logic                              odo_wrap;
  logic [fbf_pkg::TERM_W-1:0]        term_r, term_nxt;
  logic [fbf_pkg::SCALED_W-1:0]      scaled_r [fbf_pkg::MAX_VARS];
  fbf_pkg::in_word_t                 in_r;
  logic signed [fbf_pkg::VAL_W-1:0]  vals [fbf_pkg::MAX_VARS];
  logic [fbf_pkg::VCNT_W-1:0]        nv, last_var;
  logic signed [fbf_pkg::VAL_W-1:0]  cur_v, cur_lo, cur_hi;
  logic signed [fbf_pkg::VAL_W:0]    num_diff, span_diff;
  logic                              range_bad;
  logic [fbf_pkg::SCALED_W-1:0]      phase_sum;
  logic [fbf_pkg::SCALED_W+1:0]      prod;

  // divider
  logic                              div_start, div_done;
  logic [fbf_pkg::SCALED_W-1:0]      div_quot;

  // term pipeline
  logic                              push;
  term_stage_t                       push_word;
  logic                              s1_valid_r;
  term_stage_t                       s1_r;
  logic                              out_valid_r;
  fbf_pkg::out_word_t                out_r;
  logic                              out_free, s_en;
  logic signed [fbf_pkg::FEAT_W-1:0] cos_val;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r  <= fbf_pkg::ORDER_RST;
      vcount_r <= fbf_pkg::VCNT_RST;
      for (int k = 0; k < fbf_pkg::MAX_VARS; k++) begin
        low_r[k]  <= fbf_pkg::LOW_RST;
        high_r[k] <= fbf_pkg::HIGH_RST;
      end
    end else if (cfg_valid) begin
      case (cfg_index)
        fbf_pkg::REG_BASIS_ORDER: order_r   <= cfg_data[fbf_pkg::ORDER_W-1:0];
        fbf_pkg::REG_VAR_COUNT:   vcount_r  <= cfg_data[fbf_pkg::VCNT_W-1:0];
        fbf_pkg::REG_LOW_0:       low_r[0]  <= cfg_data;
        fbf_pkg::REG_HIGH_0:      high_r[0] <= cfg_data;
        fbf_pkg::REG_LOW_1:       low_r[1]  <= cfg_data;
        fbf_pkg::REG_HIGH_1:      high_r[1] <= cfg_data;
        fbf_pkg::REG_LOW_2:       low_r[2]  <= cfg_data;
        fbf_pkg::REG_HIGH_2:      high_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign nv       = (vcount_r == '0) ? fbf_pkg::VCNT_W'(1) : vcount_r;
  assign last_var = nv - fbf_pkg::VCNT_W'(1);

  assign vals[0] = in_r.var_value_0;
  assign vals[1] = in_r.var_value_1;
  assign vals[2] = in_r.var_value_2;

  assign cur_v     = vals[j_r];
  assign cur_lo    = low_r[j_r];
  assign cur_hi    = high_r[j_r];
  assign num_diff  = (fbf_pkg::VAL_W + 1)'(cur_v) - (fbf_pkg::VAL_W + 1)'(cur_lo);
  assign span_diff = (fbf_pkg::VAL_W + 1)'(cur_hi) - (fbf_pkg::VAL_W + 1)'(cur_lo);
  assign range_bad = (cur_v < cur_lo) || (cur_v > cur_hi) || (cur_hi == cur_lo);

  fbf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (num_diff[fbf_pkg::VAL_W-1:0]),
    .divisor  (span_diff[fbf_pkg::VAL_W-1:0]),
    .done     (div_done),
    .quotient (div_quot)
  );

  // phase = sum c_j * x_j, modulo two half-turns
  always_comb begin
    phase_sum = '0;
    prod      = '0;
    for (int k = 0; k < fbf_pkg::MAX_VARS; k++) begin
      prod      = (fbf_pkg::SCALED_W + 2)'(digit_r[k]) * (fbf_pkg::SCALED_W + 2)'(scaled_r[k]);
      phase_sum = phase_sum + prod[fbf_pkg::SCALED_W-1:0];
    end
  end

  // odometer, last variable fastest
  always_comb begin
    odo_wrap = 1'b1;
    for (int k = 0; k < fbf_pkg::MAX_VARS; k++) begin
      odo_next[k] = digit_r[k];
    end
    for (int k = fbf_pkg::MAX_VARS - 1; k >= 0; k--) begin
      if ((fbf_pkg::VCNT_W'(k) < nv) && odo_wrap) begin
        if (digit_r[k] == order_r) begin
          odo_next[k] = '0;
        end else begin
          odo_next[k] = digit_r[k] + fbf_pkg::ORDER_W'(1);
          odo_wrap    = 1'b0;
        end
      end
    end
  end

  assign out_free = !out_valid_r || out_ready;
  assign s_en     = !s1_valid_r || out_free;
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    j_nxt     = j_r;
    term_nxt  = term_r;
    div_start = 1'b0;
    push      = 1'b0;
    push_word = '0;
    for (int k = 0; k < fbf_pkg::MAX_VARS; k++) begin
      digit_nxt[k] = digit_r[k];
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          j_nxt     = '0;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (range_bad) begin
          state_nxt = S_ERR;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          if (j_r == last_var) begin
            state_nxt = S_TERMS;
          end else begin
            j_nxt     = j_r + 2'd1;
            state_nxt = S_CHECK;
          end
        end
      end
      S_TERMS: begin
        if (s_en) begin
          push            = 1'b1;
          push_word.phase = phase_sum;
          push_word.term  = term_r;
          push_word.last  = odo_wrap;
          for (int k = 0; k < fbf_pkg::MAX_VARS; k++) begin
            digit_nxt[k] = odo_next[k];
          end
          if (odo_wrap) begin
            term_nxt  = '0;
            state_nxt = S_IDLE;
          end else begin
            term_nxt = term_r + fbf_pkg::TERM_W'(1);
          end
        end
      end
      S_ERR: begin
        if (s_en) begin
          push           = 1'b1;
          push_word.last = 1'b1;
          push_word.err  = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      j_r     <= '0;
      term_r  <= '0;
      for (int k = 0; k < fbf_pkg::MAX_VARS; k++) begin
        digit_r[k]  <= '0;
        scaled_r[k] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      j_r     <= j_nxt;
      term_r  <= term_nxt;
      for (int k = 0; k < fbf_pkg::MAX_VARS; k++) begin
        digit_r[k] <= digit_nxt[k];
      end
      if (state_r == S_DIV && div_done) begin
        scaled_r[j_r] <= div_quot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
  end

  fbf_cos u_cos (
    .phase   (s1_r.phase),
    .feature (cos_val)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s_en) begin
        s1_valid_r <= push;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_en) begin
      s1_r <= push_word;
    end
    if (out_free) begin
      out_r.term_index    <= s1_r.term;
      out_r.feature_value <= s1_r.err ? '0 : cos_val;
      out_r.range_error   <= s1_r.err;
      out_r.last_term     <= s1_r.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.range_error |->
      out_data.last_term && out_data.term_index == '0 && out_data.feature_value == '0)
    else $error("error word malformed");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("divider finished outside divide state");

  a_feature_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.feature_value >= -16'sd16384 && out_data.feature_value <= 16'sd16384)
    else $error("feature out of Q1.14 range");

  a_ready_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_TERMS && push && odo_wrap |=> in_ready && term_r == '0)
    else $error("sequencer not idle after last term");

endmodule

// ===== tb/sv/tb_fourier_basis_features_top.sv =====
// Self-checking testbench for fourier_basis_features_top: directed rows, then random
// phases of register settings and state vectors, each feature word checked against a
// local cosine-basis predictor or a fixed word. Depends on fbf_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_fourier_basis_features_top;

  localparam int RANDOM_ITEMS   = 125;
  localparam int SETTLE_CYCLES  = 8;
  localparam int END_CYCLES     = 40;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int MAX_REPORTS    = 100;

  localparam logic [fbf_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_LO = 4'd8;
  localparam logic [fbf_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_HI = 4'd15;

  localparam fbf_pkg::out_word_t RANGE_ERR_WORD = '{term_index: '0, feature_value: '0,
                                                    range_error: 1'b1, last_term: 1'b1};
  localparam fbf_pkg::out_word_t UNIT_WORD      = '{term_index: '0,
                                                    feature_value: 16'sd16384,
                                                    range_error: 1'b0, last_term: 1'b1};

  localparam int QUARTER_WAVE [33] = '{
    16384, 16364, 16305, 16207, 16069, 15893, 15679, 15426,
    15137, 14811, 14449, 14053, 13623, 13160, 12665, 12140,
    11585, 11003, 10394, 9760, 9102, 8423, 7723, 7005,
    6270, 5520, 4756, 3981, 3196, 2404, 1606, 804,
    0
  };

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

  typedef struct packed {
    row_kind_t                      kind;
    logic [fbf_pkg::CFG_IDX_W-1:0]  idx;
    logic [fbf_pkg::CFG_DATA_W-1:0] data;
    fbf_pkg::in_word_t              item;
    logic                           fixed;
    fbf_pkg::out_word_t             fixed_word;
  } row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  fbf_pkg::in_word_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  fbf_pkg::out_word_t out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [fbf_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [fbf_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  logic [fbf_pkg::ORDER_W-1:0]      cfg_order = fbf_pkg::ORDER_RST;
  logic [fbf_pkg::VCNT_W-1:0]       cfg_vars  = fbf_pkg::VCNT_RST;
  logic signed [fbf_pkg::VAL_W-1:0] cfg_low [3] =
    '{fbf_pkg::LOW_RST, fbf_pkg::LOW_RST, fbf_pkg::LOW_RST};
  logic signed [fbf_pkg::VAL_W-1:0] cfg_high [3] =
    '{fbf_pkg::HIGH_RST, fbf_pkg::HIGH_RST, fbf_pkg::HIGH_RST};

  fbf_pkg::out_word_t feature_q [$];
  bit                 fixed_next = 1'b0;
  fbf_pkg::out_word_t fixed_result = '0;
  bit                 no_idle = 1'b0;
  bit                 hold_req = 1'b0;
  int                 errors = 0;
  int                 quiet_cycles = 0;

  const fbf_pkg::cfg_reg_t low_reg [3]  =
    '{fbf_pkg::REG_LOW_0, fbf_pkg::REG_LOW_1, fbf_pkg::REG_LOW_2};
  const fbf_pkg::cfg_reg_t high_reg [3] =
    '{fbf_pkg::REG_HIGH_0, fbf_pkg::REG_HIGH_1, fbf_pkg::REG_HIGH_2};

  fourier_basis_features_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic int quarter_mag(input int a);
    int idx;
    int frac;
    idx  = a >> fbf_pkg::LERP_BITS;
    frac = a & ((1 << fbf_pkg::LERP_BITS) - 1);
    if (idx >= 32) begin
      return 0;
    end
    return QUARTER_WAVE[idx] -
           (((QUARTER_WAVE[idx] - QUARTER_WAVE[idx + 1]) * frac) >> fbf_pkg::LERP_BITS);
  endfunction

  function automatic logic signed [fbf_pkg::FEAT_W-1:0] cos_q14(input int phase);
    int p;
    int quad;
    int q;
    int quarter;
    int mag;
    quarter = 1 << (fbf_pkg::SCALE_FRAC_BITS - 1);
    p    = phase & ((1 << (fbf_pkg::SCALE_FRAC_BITS + 1)) - 1);
    quad = p >> (fbf_pkg::SCALE_FRAC_BITS - 1);
    q    = p & (quarter - 1);
    case (quad)
      0: mag = quarter_mag(q);
      1: mag = -quarter_mag(quarter - q);
      2: mag = -quarter_mag(q);
      default: mag = quarter_mag(quarter - q);
    endcase
    return fbf_pkg::FEAT_W'(mag);
  endfunction

  function automatic void predict_features(input fbf_pkg::in_word_t w);
    int vals [3];
    int xs [3];
    int dig [3];
    int nv;
    int ord;
    int nterms;
    int span;
    int sum;
    int j;
    int t;
    fbf_pkg::out_word_t r;
    vals[0] = int'($signed(w.var_value_0));
    vals[1] = int'($signed(w.var_value_1));
    vals[2] = int'($signed(w.var_value_2));
    nv  = (cfg_vars == 0) ? 1 : int'(cfg_vars);
    ord = int'(cfg_order);
    for (j = 0; j < nv; j++) begin
      if (vals[j] < int'(cfg_low[j]) || vals[j] > int'(cfg_high[j]) ||
          cfg_high[j] == cfg_low[j]) begin
        feature_q = {feature_q, RANGE_ERR_WORD};
        return;
      end
      span  = int'(cfg_high[j]) - int'(cfg_low[j]);
      xs[j] = int'((longint'(vals[j] - int'(cfg_low[j])) <<< fbf_pkg::SCALE_FRAC_BITS)
                   / span);
    end
    nterms = 1;
    for (j = 0; j < nv; j++) begin
      nterms *= ord + 1;
      dig[j] = 0;
    end
    for (t = 0; t < nterms; t++) begin
      sum = 0;
      for (j = 0; j < nv; j++) begin
        sum += dig[j] * xs[j];
      end
      r.term_index    = fbf_pkg::TERM_W'(t);
      r.feature_value = cos_q14(sum);
      r.range_error   = 1'b0;
      r.last_term     = (t == nterms - 1);
      feature_q = {feature_q, r};
      // odometer, last variable fastest
      for (j = nv - 1; j >= 0; j--) begin
        if (dig[j] < ord) begin
          dig[j]++;
          break;
        end
        dig[j] = 0;
      end
    end
  endfunction

  // scoreboard: predict on input words, check output words, track register writes
  always @(posedge clk) begin : monitor
    fbf_pkg::out_word_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          fbf_pkg::REG_BASIS_ORDER: cfg_order   = cfg_data[fbf_pkg::ORDER_W-1:0];
          fbf_pkg::REG_VAR_COUNT:   cfg_vars    = cfg_data[fbf_pkg::VCNT_W-1:0];
          fbf_pkg::REG_LOW_0:       cfg_low[0]  = cfg_data;
          fbf_pkg::REG_HIGH_0:      cfg_high[0] = cfg_data;
          fbf_pkg::REG_LOW_1:       cfg_low[1]  = cfg_data;
          fbf_pkg::REG_HIGH_1:      cfg_high[1] = cfg_data;
          fbf_pkg::REG_LOW_2:       cfg_low[2]  = cfg_data;
          fbf_pkg::REG_HIGH_2:      cfg_high[2] = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (fixed_next) begin
          feature_q = {feature_q, fixed_result};
        end else begin
          predict_features(in_data);
        end
      end
      if (out_valid && out_ready) begin
        if (feature_q.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            $display("%0t: unexpected word: term %0d feat %0d err %0b last %0b", $time,
                     out_data.term_index, $signed(out_data.feature_value),
                     out_data.range_error, out_data.last_term);
          end
        end else begin
          want = feature_q.pop_front();
          if (out_data.term_index !== want.term_index ||
              out_data.feature_value !== want.feature_value ||
              out_data.range_error !== want.range_error ||
              out_data.last_term !== want.last_term) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
              $display("%0t: exp t%0d f%0d e%0b l%0b, got t%0d f%0d e%0b l%0b",
                       $time, want.term_index, $signed(want.feature_value),
                       want.range_error, want.last_term, out_data.term_index,
                       $signed(out_data.feature_value), out_data.range_error,
                       out_data.last_term);
            end
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d words outstanding", $time, feature_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver: random back-pressure, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        out_ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_ready = no_idle || ($urandom_range(99) >= 19);
      end
    end
  end

  task automatic offer_word(input fbf_pkg::in_word_t w, input logic fixed,
                            input fbf_pkg::out_word_t fw);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < 19) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid     = 1'b1;
    in_data      = w;
    fixed_next   = fixed;
    fixed_result = fw;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (feature_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [fbf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [fbf_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic random_bounds(input int j);
    int r;
    int lo;
    int hi;
    int a;
    int b;
    r = $urandom_range(99);
    a = int'($signed(16'($urandom)));
    b = int'($signed(16'($urandom)));
    if (r < 6) begin
      lo = a;
      hi = a;
    end else if (r < 12) begin
      lo = (a > b) ? a : b;
      hi = (a > b) ? b : a;
      if (lo == hi) hi = lo - 1;
      if (hi < -32768) begin
        lo = 0;
        hi = -1;
      end
    end else if (r < 25) begin
      lo = -32768;
      hi = 32767;
    end else if (r < 60) begin
      lo = int'($urandom_range(0, 64000)) - 32768;
      hi = lo + int'($urandom_range(1, 3000));
      if (hi > 32767) hi = 32767;
    end else begin
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      if (lo == hi) hi = (lo == 32767) ? lo : lo + 1;
    end
    write_reg(low_reg[j], 16'(lo));
    write_reg(high_reg[j], 16'(hi));
  endtask

  task automatic random_state(output fbf_pkg::in_word_t w);
    logic [fbf_pkg::VAL_W-1:0] v [3];
    int lo;
    int hi;
    int r;
    int j;
    bit noise;
    noise = ($urandom_range(99) < 15);
    for (j = 0; j < 3; j++) begin
      lo = int'(cfg_low[j]);
      hi = int'(cfg_high[j]);
      r  = $urandom_range(99);
      if (noise || hi <= lo) begin
        v[j] = 16'($urandom);
      end else if (r < 5) begin
        v[j] = 16'(lo);
      end else if (r < 10) begin
        v[j] = 16'(hi);
      end else begin
        v[j] = 16'(lo + int'($urandom_range(0, hi - lo)));
      end
    end
    w = {v[0], v[1], v[2]};
  endtask

  function automatic row_t cfg_row(input logic [fbf_pkg::CFG_IDX_W-1:0] idx,
                                   input logic [fbf_pkg::CFG_DATA_W-1:0] data);
    row_t r;
    r      = '0;
    r.kind = ROW_CFG;
    r.idx  = idx;
    r.data = data;
    return r;
  endfunction

  function automatic row_t item_row(input int a, input int b, input int c,
                                    input logic fixed = 1'b0,
                                    input fbf_pkg::out_word_t fw = '0);
    row_t r;
    r            = '0;
    r.kind       = ROW_ITEM;
    r.item       = {16'(a), 16'(b), 16'(c)};
    r.fixed      = fixed;
    r.fixed_word = fw;
    return r;
  endfunction

  initial begin
    row_t              rows [$];
    fbf_pkg::in_word_t w;
    int                i;
    int                j;
    int                phase;
    int                random_sent;
    int                count;
    int                ord;
    int                nv;
    bit                in_burst;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    rows = '{
      item_row(0, 0, 0),
      item_row(256, 256, 256),
      item_row(128, 64, 192),
      item_row(-1, 0, 0, 1'b1, RANGE_ERR_WORD),
      item_row(0, 0, 257, 1'b1, RANGE_ERR_WORD),
      cfg_row(fbf_pkg::REG_BASIS_ORDER, 16'hFFFC),
      cfg_row(fbf_pkg::REG_VAR_COUNT, 16'hA5A5),
      item_row(200, -32768, 32767, 1'b1, UNIT_WORD),
      cfg_row(fbf_pkg::REG_VAR_COUNT, 16'h0000),
      cfg_row(fbf_pkg::REG_BASIS_ORDER, 16'h0003),
      item_row(77, -32768, 32767),
      cfg_row(fbf_pkg::REG_LOW_0, 16'h8000),
      cfg_row(fbf_pkg::REG_HIGH_0, 16'h7FFF),
      item_row(-32768, 0, 0),
      item_row(32767, 0, 0),
      item_row(0, 0, 0),
      cfg_row(fbf_pkg::REG_HIGH_0, 16'h8000),
      item_row(-32768, 0, 0, 1'b1, RANGE_ERR_WORD),
      cfg_row(fbf_pkg::REG_LOW_0, 16'd100),
      cfg_row(fbf_pkg::REG_HIGH_0, 16'd50),
      item_row(75, 0, 0, 1'b1, RANGE_ERR_WORD),
      cfg_row(REG_UNMAPPED_LO, 16'hFFFF),
      cfg_row(REG_UNMAPPED_HI, 16'h0000),
      item_row(75, 0, 0, 1'b1, RANGE_ERR_WORD),
      cfg_row(fbf_pkg::REG_LOW_0, 16'd0),
      cfg_row(fbf_pkg::REG_HIGH_0, 16'd256),
      cfg_row(fbf_pkg::REG_LOW_1, -16'sd256),
      cfg_row(fbf_pkg::REG_HIGH_1, 16'd256),
      cfg_row(fbf_pkg::REG_LOW_2, -16'sd1000),
      cfg_row(fbf_pkg::REG_HIGH_2, 16'd1000),
      cfg_row(fbf_pkg::REG_VAR_COUNT, 16'd3),
      cfg_row(fbf_pkg::REG_BASIS_ORDER, 16'd2),
      item_row(128, 0, 0),
      item_row(0, -256, 1000),
      item_row(0, 257, 0, 1'b1, RANGE_ERR_WORD),
      item_row(0, 0, -1001, 1'b1, RANGE_ERR_WORD),
      cfg_row(fbf_pkg::REG_BASIS_ORDER, 16'd3),
      item_row(256, 256, -1000),
      cfg_row(fbf_pkg::REG_VAR_COUNT, 16'd2),
      item_row(64, 128, -32768)
    };

    in_burst = 1'b0;
    for (i = 0; i < rows.size(); i++) begin
      if (rows[i].kind == ROW_CFG) begin
        if (in_burst) drain();
        in_burst = 1'b0;
        write_reg(rows[i].idx, rows[i].data);
      end else begin
        in_burst = 1'b1;
        offer_word(rows[i].item, rows[i].fixed, rows[i].fixed_word);
      end
    end

    random_sent = 0;
    phase = 0;
    while (random_sent < RANDOM_ITEMS) begin
      drain();
      if (phase == 1) begin
        ord = 3;
        nv  = 3;
      end else begin
        ord = $urandom_range(0, 3);
        nv  = $urandom_range(0, 3);
        if (ord == 3 && nv == 3 && $urandom_range(99) < 70) ord = $urandom_range(0, 2);
      end
      write_reg(fbf_pkg::REG_BASIS_ORDER, (16'($urandom) & 16'hFFFC) | 16'(ord));
      write_reg(fbf_pkg::REG_VAR_COUNT, (16'($urandom) & 16'hFFFC) | 16'(nv));
      for (j = 0; j < 3; j++) begin
        random_bounds(j);
      end
      count = (ord == 3 && nv == 3) ? 6 : $urandom_range(8, 20);
      no_idle = (phase == 3);
      if (phase == 1) hold_req = 1'b1;
      for (i = 0; i < count; i++) begin
        random_state(w);
        offer_word(w, 1'b0, '0);
        random_sent++;
      end
      no_idle = 1'b0;
      phase++;
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (feature_q.size() != 0) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);
    if (feature_q.size() != 0) begin
      $display("%0t: %0d expected words never arrived", $time, feature_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== fourier_basis_features_top.f =====
rtl/fbf_pkg.sv
rtl/fbf_div.sv
rtl/fbf_cos.sv
rtl/fourier_basis_features_top.sv
tb/sv/tb_fourier_basis_features_top.sv
